/* rtl/core/ats_pkg.sv */
// Shared types, widths and codes for the bilinear atlas texel sampler.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package ats_pkg;

   // Atlas geometry
   localparam int IDX_BITS       = 8;
   localparam int MAX_RES        = 1 << IDX_BITS;
   localparam int RES_BITS       = IDX_BITS + 1;
   localparam logic [RES_BITS-1:0] RES_RESET = RES_BITS'(MAX_RES);

   // Texel format: three channels packed red, green, blue from the top
   localparam int CHAN_BITS      = 16;
   localparam int NUM_CHANNELS   = 3;
   localparam int TEXEL_BITS     = NUM_CHANNELS * CHAN_BITS;

   // Four banks split by column and row parity, each a quarter of the atlas
   localparam int NUM_BANKS      = 4;
   localparam int BANK_SEL_BITS  = 2;
   localparam int BANK_ADDR_BITS = 2 * (IDX_BITS - 1);
   localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;

   // Coordinate formats
   localparam int CHART_BITS     = 16;                        // Q8.8
   localparam int COORD_BITS     = 17;                        // Q1.16, up to 1.0 and beyond
   localparam int UV_FRAC_BITS   = 16;
   localparam int PROD_BITS      = CHART_BITS + COORD_BITS;
   localparam int OFFS_BITS      = PROD_BITS - UV_FRAC_BITS;  // Q.8 offset into chart
   localparam int FRAC_BITS      = 8;
   localparam int POS_BITS       = OFFS_BITS + 1;
   localparam int CELL_BITS      = POS_BITS - FRAC_BITS;
   localparam int HALF_TEXEL     = 1 << (FRAC_BITS - 1);
   localparam int WEIGHT_BITS    = FRAC_BITS + 1;
   localparam int ONE_WEIGHT     = 1 << FRAC_BITS;

   // Transaction function codes
   localparam logic FUNC_WRITE   = 1'b0;
   localparam logic FUNC_SAMPLE  = 1'b1;

   // Neighbor pair along one axis, already clamped, plus blend fraction
   typedef struct packed {
      logic [IDX_BITS-1:0]  lo;
      logic [IDX_BITS-1:0]  hi;
      logic [FRAC_BITS-1:0] frac;
   } axis_type;

endpackage

/* rtl/core/bilinear_atlas_texel_sampler.sv */
// Bilinear atlas texel sampler: top level, four-bank texel store and blend pipeline.
// A sample passes through the stage-1, bank read, blend row and result registers.
// Throughput: one transaction per cycle, write or sample, while the output drains,
// set by one read of each parity bank per cycle; a write uses a slot, returns nothing.
// Reset (synchronous): clears all pipeline valids, sets csr_res_ff to 256; the
// texel store is not cleared and holds undefined data until written.
module bilinear_atlas_texel_sampler (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [ats_pkg::IDX_BITS-1:0]       req_texel_x,
   input  logic [ats_pkg::IDX_BITS-1:0]       req_texel_y,
   input  logic [ats_pkg::CHAN_BITS-1:0]      req_texel_red,
   input  logic [ats_pkg::CHAN_BITS-1:0]      req_texel_green,
   input  logic [ats_pkg::CHAN_BITS-1:0]      req_texel_blue,
   input  logic [ats_pkg::CHART_BITS-1:0]     req_chart_x,
   input  logic [ats_pkg::CHART_BITS-1:0]     req_chart_y,
   input  logic [ats_pkg::CHART_BITS-1:0]     req_chart_w,
   input  logic [ats_pkg::CHART_BITS-1:0]     req_chart_h,
   input  logic [ats_pkg::COORD_BITS-1:0]     req_coord_u,
   input  logic [ats_pkg::COORD_BITS-1:0]     req_coord_v,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ats_pkg::CHAN_BITS-1:0]      rsp_sample_red,
   output logic [ats_pkg::CHAN_BITS-1:0]      rsp_sample_green,
   output logic [ats_pkg::CHAN_BITS-1:0]      rsp_sample_blue,

   input  logic                               csr_wr_en,
   input  logic [ats_pkg::RES_BITS-1:0]       csr_wr_data
);

   // ------------------------------------------------------------------
   // Configuration: atlas side, used as 1..MAX_RES
   // ------------------------------------------------------------------
   logic [ats_pkg::RES_BITS-1:0] csr_res_ff;
   logic [ats_pkg::RES_BITS-1:0] res_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_res_ff <= ats_pkg::RES_RESET;
      end else if (csr_wr_en) begin
         csr_res_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (csr_res_ff == '0) begin
         res_eff = ats_pkg::RES_BITS'(1);
      end else if (csr_res_ff > ats_pkg::RES_RESET) begin
         res_eff = ats_pkg::RES_RESET;
      end else begin
         res_eff = csr_res_ff;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: every stage advances together whenever the output
   // register is empty or being drained, so a full pipe still takes one
   // transaction per cycle while the consumer keeps up.
   // ------------------------------------------------------------------
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ------------------------------------------------------------------
   // Stage 1: multiply u*w and v*h, keep the Q.8 part of each product
   // ------------------------------------------------------------------
   logic [ats_pkg::PROD_BITS-1:0]  prod_x, prod_y;
   logic                           s1_valid_ff;
   logic                           s1_func_ff;
   logic [ats_pkg::IDX_BITS-1:0]   s1_wr_x_ff, s1_wr_y_ff;
   logic [ats_pkg::TEXEL_BITS-1:0] s1_wr_data_ff;
   logic [ats_pkg::CHART_BITS-1:0] s1_org_x_ff, s1_org_y_ff;
   logic [ats_pkg::OFFS_BITS-1:0]  s1_offs_x_ff, s1_offs_y_ff;

   assign prod_x = ats_pkg::PROD_BITS'(req_coord_u) * ats_pkg::PROD_BITS'(req_chart_w);
   assign prod_y = ats_pkg::PROD_BITS'(req_coord_v) * ats_pkg::PROD_BITS'(req_chart_h);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_func_ff    <= req_func;
         s1_wr_x_ff    <= req_texel_x;
         s1_wr_y_ff    <= req_texel_y;
         s1_wr_data_ff <= {req_texel_red, req_texel_green, req_texel_blue};
         s1_org_x_ff   <= req_chart_x;
         s1_org_y_ff   <= req_chart_y;
         s1_offs_x_ff  <= prod_x[ats_pkg::PROD_BITS-1:ats_pkg::UV_FRAC_BITS];
         s1_offs_y_ff  <= prod_y[ats_pkg::PROD_BITS-1:ats_pkg::UV_FRAC_BITS];
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: locate the neighbors and access the store. Writes and reads
   // both happen on the edge that leaves this stage, one transaction at a
   // time, so program order is kept without any forwarding.
   // ------------------------------------------------------------------
   ats_pkg::axis_type ax, ay;

   ats_locate u_locate_x (
      .origin (s1_org_x_ff),
      .offset (s1_offs_x_ff),
      .res    (res_eff),
      .axis   (ax)
   );

   ats_locate u_locate_y (
      .origin (s1_org_y_ff),
      .offset (s1_offs_y_ff),
      .res    (res_eff),
      .axis   (ay)
   );

   logic                           s1_is_write;
   logic [ats_pkg::BANK_ADDR_BITS-1:0] wr_addr;
   logic [ats_pkg::TEXEL_BITS-1:0] bank_rd [ats_pkg::NUM_BANKS];

   assign s1_is_write = s1_valid_ff && (s1_func_ff == ats_pkg::FUNC_WRITE) && advance;
   assign wr_addr     = {s1_wr_y_ff[ats_pkg::IDX_BITS-1:1], s1_wr_x_ff[ats_pkg::IDX_BITS-1:1]};

   // Bank b holds texels whose column parity is b%2 and row parity is b/2.
   // Each bank serves whichever neighbor has its parity; when a clamp makes
   // both neighbors equal, the one bank's data is used for both.
   for (genvar b = 0; b < ats_pkg::NUM_BANKS; b++) begin : g_bank
      localparam logic BX = (b % 2) == 1;
      localparam logic BY = (b / 2) == 1;

      logic [ats_pkg::IDX_BITS-1:0]       col, row;
      logic [ats_pkg::BANK_ADDR_BITS-1:0] rd_addr;
      logic                               wr_en;

      assign col     = (ax.lo[0] == BX) ? ax.lo : ax.hi;
      assign row     = (ay.lo[0] == BY) ? ay.lo : ay.hi;
      assign rd_addr = {row[ats_pkg::IDX_BITS-1:1], col[ats_pkg::IDX_BITS-1:1]};
      assign wr_en   = s1_is_write && (s1_wr_x_ff[0] == BX) && (s1_wr_y_ff[0] == BY);

      ats_bank u_bank (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (s1_wr_data_ff),
         .rd_en   (advance),
         .rd_addr (rd_addr),
         .rd_data (bank_rd[b])
      );
   end

   // Steering info travels alongside the read data
   logic                          s2_valid_ff;
   logic                          s2_px0_ff, s2_py0_ff;
   logic                          s2_xsame_ff, s2_ysame_ff;
   logic [ats_pkg::FRAC_BITS-1:0] s2_tx_ff, s2_ty_ff;
   logic                          s2_valid_in;

   assign s2_valid_in = s1_valid_ff && (s1_func_ff == ats_pkg::FUNC_SAMPLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_px0_ff   <= ax.lo[0];
         s2_py0_ff   <= ay.lo[0];
         s2_xsame_ff <= (ax.lo == ax.hi);
         s2_ysame_ff <= (ay.lo == ay.hi);
         s2_tx_ff    <= ax.frac;
         s2_ty_ff    <= ay.frac;
      end
   end

   // ------------------------------------------------------------------
   // Stages 3 and 4: route bank outputs to corners, then blend per channel
   // ------------------------------------------------------------------
   logic                           px1, py1;
   logic [ats_pkg::TEXEL_BITS-1:0] t00, t10, t01, t11;
   logic [ats_pkg::CHAN_BITS-1:0]  chan_out [ats_pkg::NUM_CHANNELS];
   logic                           s3_valid_ff;

   assign px1 = s2_xsame_ff ? s2_px0_ff : !s2_px0_ff;
   assign py1 = s2_ysame_ff ? s2_py0_ff : !s2_py0_ff;
   assign t00 = bank_rd[{s2_py0_ff, s2_px0_ff}];
   assign t10 = bank_rd[{s2_py0_ff, px1}];
   assign t01 = bank_rd[{py1, s2_px0_ff}];
   assign t11 = bank_rd[{py1, px1}];

   for (genvar ch = 0; ch < ats_pkg::NUM_CHANNELS; ch++) begin : g_chan
      localparam int LSB = (ats_pkg::NUM_CHANNELS - 1 - ch) * ats_pkg::CHAN_BITS;

      ats_blend u_blend (
         .clock  (clock),
         .enable (advance),
         .c00    (t00[LSB +: ats_pkg::CHAN_BITS]),
         .c10    (t10[LSB +: ats_pkg::CHAN_BITS]),
         .c01    (t01[LSB +: ats_pkg::CHAN_BITS]),
         .c11    (t11[LSB +: ats_pkg::CHAN_BITS]),
         .tx     (s2_tx_ff),
         .ty     (s2_ty_ff),
         .result (chan_out[ch])
      );
   end

   // Hold the result until taken; advance only when the slot frees up
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_red   = chan_out[0];
   assign rsp_sample_green = chan_out[1];
   assign rsp_sample_blue  = chan_out[2];

endmodule

/* rtl/core/ats_locate.sv */
// Maps one axis of a sample to its two clamped neighbor indices and fraction.
// Depends on ats_pkg.
module ats_locate (
   input  logic [ats_pkg::CHART_BITS-1:0] origin,
   input  logic [ats_pkg::OFFS_BITS-1:0]  offset,
   input  logic [ats_pkg::RES_BITS-1:0]   res,
   output ats_pkg::axis_type              axis
);

   logic [ats_pkg::POS_BITS-1:0]  pos;
   logic [ats_pkg::CELL_BITS-1:0] whole;
   logic [ats_pkg::CELL_BITS-1:0] res_ext;
   logic [ats_pkg::IDX_BITS-1:0]  last;

   // pos is the texel-center coordinate shifted up by one texel, never negative
   assign pos     = ats_pkg::POS_BITS'(origin) + ats_pkg::POS_BITS'(offset)
                  + ats_pkg::POS_BITS'(ats_pkg::HALF_TEXEL);
   assign whole   = pos[ats_pkg::POS_BITS-1:ats_pkg::FRAC_BITS];
   assign res_ext = ats_pkg::CELL_BITS'(res);
   assign last    = ats_pkg::IDX_BITS'(res - ats_pkg::RES_BITS'(1));

   always_comb begin
      axis.frac = pos[ats_pkg::FRAC_BITS-1:0];
      // floor is whole - 1; clamp it below at zero and above at the last texel
      if (whole == '0) begin
         axis.lo = '0;
      end else if (whole > res_ext) begin
         axis.lo = last;
      end else begin
         axis.lo = ats_pkg::IDX_BITS'(whole - ats_pkg::CELL_BITS'(1));
      end
      if (whole >= res_ext) begin
         axis.hi = last;
      end else begin
         axis.hi = ats_pkg::IDX_BITS'(whole);
      end
   end

endmodule

/* rtl/core/ats_bank.sv */
// One parity bank of the texel store: one write port, one registered read port.
// Depends on ats_pkg.
module ats_bank (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [ats_pkg::BANK_ADDR_BITS-1:0] wr_addr,
   input  logic [ats_pkg::TEXEL_BITS-1:0]     wr_data,
   input  logic                               rd_en,
   input  logic [ats_pkg::BANK_ADDR_BITS-1:0] rd_addr,
   output logic [ats_pkg::TEXEL_BITS-1:0]     rd_data
);

   logic [ats_pkg::TEXEL_BITS-1:0] mem [ats_pkg::BANK_DEPTH];
   logic [ats_pkg::TEXEL_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ats_blend.sv */
// Two-stage bilinear blend of one channel: horizontal lerps, then vertical.
// Depends on ats_pkg.
module ats_blend (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [ats_pkg::CHAN_BITS-1:0]   c00,
   input  logic [ats_pkg::CHAN_BITS-1:0]   c10,
   input  logic [ats_pkg::CHAN_BITS-1:0]   c01,
   input  logic [ats_pkg::CHAN_BITS-1:0]   c11,
   input  logic [ats_pkg::FRAC_BITS-1:0]   tx,
   input  logic [ats_pkg::FRAC_BITS-1:0]   ty,
   output logic [ats_pkg::CHAN_BITS-1:0]   result
);

   localparam int ROW_BITS = ats_pkg::CHAN_BITS + ats_pkg::WEIGHT_BITS;
   localparam int SUM_BITS = ROW_BITS + ats_pkg::WEIGHT_BITS;
   localparam int SHIFT    = 2 * ats_pkg::FRAC_BITS;
   localparam int TOP      = ats_pkg::CHAN_BITS + SHIFT;

   logic [ats_pkg::WEIGHT_BITS-1:0] wx0;
   logic [ats_pkg::WEIGHT_BITS-1:0] wy0;
   logic [ROW_BITS-1:0]             row_a_in, row_b_in;
   logic [ROW_BITS-1:0]             row_a_ff, row_b_ff;
   logic [ats_pkg::FRAC_BITS-1:0]   ty_ff;
   logic [SUM_BITS-1:0]             sum;
   logic [ats_pkg::CHAN_BITS-1:0]   result_in, result_ff;

   assign wx0      = ats_pkg::WEIGHT_BITS'(ats_pkg::ONE_WEIGHT) - ats_pkg::WEIGHT_BITS'(tx);
   assign row_a_in = ROW_BITS'(c00) * ROW_BITS'(wx0) + ROW_BITS'(c10) * ROW_BITS'(tx);
   assign row_b_in = ROW_BITS'(c01) * ROW_BITS'(wx0) + ROW_BITS'(c11) * ROW_BITS'(tx);

   assign wy0 = ats_pkg::WEIGHT_BITS'(ats_pkg::ONE_WEIGHT) - ats_pkg::WEIGHT_BITS'(ty_ff);
   assign sum = SUM_BITS'(row_a_ff) * SUM_BITS'(wy0) + SUM_BITS'(row_b_ff) * SUM_BITS'(ty_ff);

   // saturate, though weights summing to one keep the value in range
   assign result_in = (|sum[SUM_BITS-1:TOP]) ? '1 : sum[TOP-1:SHIFT];

   always_ff @(posedge clock) begin
      if (enable) begin
         row_a_ff  <= row_a_in;
         row_b_ff  <= row_b_in;
         ty_ff     <= ty;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* dv/bilinear_atlas_texel_sampler_tb.sv */
// Self-checking testbench for the bilinear atlas texel sampler: random-gap stimulus,
// a predictor of the clamp-to-edge bilinear blend, and in-order response checks.
// Depends on ats_pkg and the bilinear_atlas_texel_sampler RTL.
module bilinear_atlas_texel_sampler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDX_BITS     = ats_pkg::IDX_BITS;
   localparam int CHAN_BITS    = ats_pkg::CHAN_BITS;
   localparam int CHART_BITS   = ats_pkg::CHART_BITS;
   localparam int COORD_BITS   = ats_pkg::COORD_BITS;
   localparam int NUM_CHANNELS = ats_pkg::NUM_CHANNELS;
   localparam int TEXEL_BITS   = ats_pkg::TEXEL_BITS;
   localparam int MAX_RES      = ats_pkg::MAX_RES;
   localparam int RES_BITS     = ats_pkg::RES_BITS;
   localparam int HALF_TEXEL   = ats_pkg::HALF_TEXEL;
   localparam int FRAC_BITS    = ats_pkg::FRAC_BITS;
   localparam int UV_FRAC_BITS = ats_pkg::UV_FRAC_BITS;
   localparam int ONE_WEIGHT   = ats_pkg::ONE_WEIGHT;
   localparam logic [RES_BITS-1:0] RES_RESET = ats_pkg::RES_RESET;

   localparam int PIPE_LATENCY = 3;           // accept-to-rsp_valid for a sample
   localparam int RANDOM_ITEMS = 700;
   localparam int NUM_PHASES   = 13;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int HALF_PERIOD  = 4;

   typedef struct {
      bit                  func;
      bit [IDX_BITS-1:0]   texel_x;
      bit [IDX_BITS-1:0]   texel_y;
      bit [CHAN_BITS-1:0]  red;
      bit [CHAN_BITS-1:0]  green;
      bit [CHAN_BITS-1:0]  blue;
      bit [CHART_BITS-1:0] chart_x;
      bit [CHART_BITS-1:0] chart_y;
      bit [CHART_BITS-1:0] chart_w;
      bit [CHART_BITS-1:0] chart_h;
      bit [COORD_BITS-1:0] coord_u;
      bit [COORD_BITS-1:0] coord_v;
   } atlas_request_type;

   // Filtered value per channel, red first
   typedef struct {
      bit [CHAN_BITS-1:0] level [NUM_CHANNELS];
   } filtered_texel_type;

   // Mirror of the atlas plus the queue of filtered values still owed by the block
   class texel_scoreboard;
      bit [TEXEL_BITS-1:0] texels [MAX_RES*MAX_RES];
      bit [RES_BITS-1:0]   atlas_res;
      filtered_texel_type  filtered_q [$];
      int                  errors;
      int                  writes_seen;
      int                  samples_checked;

      function new();
         atlas_res       = RES_RESET;
         errors          = 0;
         writes_seen     = 0;
         samples_checked = 0;
      endfunction

      // Side length actually in use: zero acts as one, oversize acts as the full store
      function int unsigned span();
         if (atlas_res == 0) return 1;
         if (atlas_res > MAX_RES) return MAX_RES;
         return int'(atlas_res);
      endfunction

      function bit [IDX_BITS-1:0] clamp_index(longint whole);
         longint top;
         top = longint'(span()) - 1;
         if (whole < 0) return '0;
         if (whole > top) return top[IDX_BITS-1:0];
         return whole[IDX_BITS-1:0];
      endfunction

      // Map origin + coord*size - half a texel to a clamped neighbor pair and fraction
      function void resolve_axis(input bit [CHART_BITS-1:0] origin,
                                 input bit [COORD_BITS-1:0] coord,
                                 input bit [CHART_BITS-1:0] size,
                                 output bit [IDX_BITS-1:0] lo,
                                 output bit [IDX_BITS-1:0] hi,
                                 output bit [FRAC_BITS-1:0] frac);
         longint unsigned pos;
         longint          whole;
         pos   = longint'(origin) + ((longint'(coord) * longint'(size)) >> UV_FRAC_BITS)
                 + longint'(HALF_TEXEL);
         whole = longint'(pos >> FRAC_BITS) - 1;
         frac  = pos[FRAC_BITS-1:0];
         lo    = clamp_index(whole);
         hi    = clamp_index(whole + 1);
      endfunction

      function bit [CHAN_BITS-1:0] blend(input bit [CHAN_BITS-1:0] c00, c10, c01, c11,
                                         input bit [FRAC_BITS-1:0] fx, fy);
         longint unsigned wx, wy, top_row, bot_row, mix;
         wx      = 64'(fx);
         wy      = 64'(fy);
         top_row = 64'(c00) * (64'(ONE_WEIGHT) - wx) + 64'(c10) * wx;
         bot_row = 64'(c01) * (64'(ONE_WEIGHT) - wx) + 64'(c11) * wx;
         mix     = (top_row * (64'(ONE_WEIGHT) - wy) + bot_row * wy) >> (2 * FRAC_BITS);
         if (mix > 64'((1 << CHAN_BITS) - 1)) return '1;
         return mix[CHAN_BITS-1:0];
      endfunction

      function void note_request(atlas_request_type q);
         bit [IDX_BITS-1:0]   x0, x1, y0, y1;
         bit [FRAC_BITS-1:0]  tx, ty;
         bit [TEXEL_BITS-1:0] t00, t10, t01, t11;
         filtered_texel_type  f;
         int                  sh;
         if (q.func == ats_pkg::FUNC_WRITE) begin
            texels[{q.texel_y, q.texel_x}] = {q.red, q.green, q.blue};
            writes_seen++;
            return;
         end
         resolve_axis(q.chart_x, q.coord_u, q.chart_w, x0, x1, tx);
         resolve_axis(q.chart_y, q.coord_v, q.chart_h, y0, y1, ty);
         t00 = texels[{y0, x0}];
         t10 = texels[{y0, x1}];
         t01 = texels[{y1, x0}];
         t11 = texels[{y1, x1}];
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            sh = (NUM_CHANNELS - 1 - ch) * CHAN_BITS;
            f.level[ch] = blend(t00[sh +: CHAN_BITS], t10[sh +: CHAN_BITS],
                                t01[sh +: CHAN_BITS], t11[sh +: CHAN_BITS], tx, ty);
         end
         filtered_q.push_back(f);
      endfunction

      function void check_response(input logic [CHAN_BITS-1:0] red, green, blue);
         filtered_texel_type   f;
         logic [CHAN_BITS-1:0] got [NUM_CHANNELS];
         string                names [NUM_CHANNELS];
         names = '{"sample_red", "sample_green", "sample_blue"};
         got   = '{red, green, blue};
         if (filtered_q.size() == 0) begin
            $error("response with no sample outstanding: red %h green %h blue %h",
                   red, green, blue);
            errors++;
            return;
         end
         f = filtered_q.pop_front();
         samples_checked++;
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (got[ch] !== f.level[ch]) begin
               $error("%s mismatch: expected %h, actual %h", names[ch], f.level[ch], got[ch]);
               errors++;
            end
         end
      endfunction

      function int pending();
         return filtered_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_func;
   logic [IDX_BITS-1:0]   req_texel_x;
   logic [IDX_BITS-1:0]   req_texel_y;
   logic [CHAN_BITS-1:0]  req_texel_red;
   logic [CHAN_BITS-1:0]  req_texel_green;
   logic [CHAN_BITS-1:0]  req_texel_blue;
   logic [CHART_BITS-1:0] req_chart_x;
   logic [CHART_BITS-1:0] req_chart_y;
   logic [CHART_BITS-1:0] req_chart_w;
   logic [CHART_BITS-1:0] req_chart_h;
   logic [COORD_BITS-1:0] req_coord_u;
   logic [COORD_BITS-1:0] req_coord_v;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [CHAN_BITS-1:0]  rsp_sample_red;
   logic [CHAN_BITS-1:0]  rsp_sample_green;
   logic [CHAN_BITS-1:0]  rsp_sample_blue;
   logic                  csr_wr_en;
   logic [RES_BITS-1:0]   csr_wr_data;

   texel_scoreboard       sb;
   bit                    texel_loaded [MAX_RES*MAX_RES];   // texels the stimulus has written
   bit [RES_BITS-1:0]     phase_res [NUM_PHASES];
   int                    items_sent = 0;
   int                    send_burst = 0;
   int                    recv_burst = 0;
   int                    cycle_count = 0;

   bilinear_atlas_texel_sampler dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_texel_x      (req_texel_x),
      .req_texel_y      (req_texel_y),
      .req_texel_red    (req_texel_red),
      .req_texel_green  (req_texel_green),
      .req_texel_blue   (req_texel_blue),
      .req_chart_x      (req_chart_x),
      .req_chart_y      (req_chart_y),
      .req_chart_w      (req_chart_w),
      .req_chart_h      (req_chart_h),
      .req_coord_u      (req_coord_u),
      .req_coord_v      (req_coord_v),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample_red   (rsp_sample_red),
      .rsp_sample_green (rsp_sample_green),
      .rsp_sample_blue  (rsp_sample_blue),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned idle_cycles();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 83) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Bias channel values toward both rails
   function automatic bit [CHAN_BITS-1:0] rand_chan();
      case ($urandom_range(0, 3))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return CHAN_BITS'($urandom);
         end
      endcase
   endfunction

   // Unused fields of each kind of transaction still carry random bits
   function automatic atlas_request_type write_item(bit [IDX_BITS-1:0] x, y,
                                                    bit [CHAN_BITS-1:0] r, g, b);
      atlas_request_type q;
      q.func    = ats_pkg::FUNC_WRITE;
      q.texel_x = x;
      q.texel_y = y;
      q.red     = r;
      q.green   = g;
      q.blue    = b;
      q.chart_x = CHART_BITS'($urandom);
      q.chart_y = CHART_BITS'($urandom);
      q.chart_w = CHART_BITS'($urandom);
      q.chart_h = CHART_BITS'($urandom);
      q.coord_u = COORD_BITS'($urandom);
      q.coord_v = COORD_BITS'($urandom);
      return q;
   endfunction

   function automatic atlas_request_type sample_item(bit [CHART_BITS-1:0] cx, cy, cw, ch,
                                                     bit [COORD_BITS-1:0] u, v);
      atlas_request_type q;
      q.func    = ats_pkg::FUNC_SAMPLE;
      q.texel_x = IDX_BITS'($urandom);
      q.texel_y = IDX_BITS'($urandom);
      q.red     = CHAN_BITS'($urandom);
      q.green   = CHAN_BITS'($urandom);
      q.blue    = CHAN_BITS'($urandom);
      q.chart_x = cx;
      q.chart_y = cy;
      q.chart_w = cw;
      q.chart_h = ch;
      q.coord_u = u;
      q.coord_v = v;
      return q;
   endfunction

   // One axis of a random sample: mostly a chart inside the atlas, else raw or edge values
   function automatic void random_axis(input int unsigned res,
                                       output bit [CHART_BITS-1:0] origin,
                                       output bit [COORD_BITS-1:0] coord,
                                       output bit [CHART_BITS-1:0] size);
      int unsigned r, lim;
      r   = $urandom_range(0, 99);
      lim = (res * ONE_WEIGHT > 65535) ? 65535 : res * ONE_WEIGHT;
      if (r < 70) begin
         origin = CHART_BITS'($urandom_range(0, lim));
         size   = CHART_BITS'($urandom_range(0, lim));
         coord  = COORD_BITS'($urandom_range(0, 1 << UV_FRAC_BITS));
      end else if (r < 85) begin
         origin = CHART_BITS'($urandom);
         size   = CHART_BITS'($urandom);
         coord  = COORD_BITS'($urandom);
      end else begin
         case ($urandom_range(0, 2))
            0: begin
               origin = '0;
            end
            1: begin
               origin = '1;
            end
            default: begin
               origin = CHART_BITS'(HALF_TEXEL);
            end
         endcase
         size = ($urandom_range(0, 1) == 0) ? '0 : '1;
         case ($urandom_range(0, 2))
            0: begin
               coord = '0;
            end
            1: begin
               coord = COORD_BITS'(1 << UV_FRAC_BITS);
            end
            default: begin
               coord = '1;
            end
         endcase
      end
   endfunction

   function automatic atlas_request_type random_sample(int unsigned res);
      bit [CHART_BITS-1:0] cx, cy, cw, ch;
      bit [COORD_BITS-1:0] u, v;
      random_axis(res, cx, u, cw);
      random_axis(res, cy, v, ch);
      return sample_item(cx, cy, cw, ch, u, v);
   endfunction

   // Drive one transaction and hold it until the block takes it
   task automatic push_request(atlas_request_type q);
      int unsigned gap;
      if (send_burst > 0) begin
         gap = 0;
         send_burst--;
      end else begin
         gap = idle_cycles();
         if ($urandom_range(0, 99) < 2) send_burst = $urandom_range(30, 80);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= q.func;
      req_texel_x     <= q.texel_x;
      req_texel_y     <= q.texel_y;
      req_texel_red   <= q.red;
      req_texel_green <= q.green;
      req_texel_blue  <= q.blue;
      req_chart_x     <= q.chart_x;
      req_chart_y     <= q.chart_y;
      req_chart_w     <= q.chart_w;
      req_chart_h     <= q.chart_h;
      req_coord_u     <= q.coord_u;
      req_coord_v     <= q.coord_v;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      // Transaction taken at this edge: advance the predictor in acceptance order
      sb.note_request(q);
      if (q.func == ats_pkg::FUNC_WRITE) texel_loaded[{q.texel_y, q.texel_x}] = 1'b1;
      items_sent++;
   endtask

   // Load any neighbor the sample will read that was never written, then send it
   task automatic send_sample(atlas_request_type q);
      bit [IDX_BITS-1:0]  x0, x1, y0, y1, cx, cy;
      bit [FRAC_BITS-1:0] fr;
      int                 corner;
      sb.resolve_axis(q.chart_x, q.coord_u, q.chart_w, x0, x1, fr);
      sb.resolve_axis(q.chart_y, q.coord_v, q.chart_h, y0, y1, fr);
      for (corner = 0; corner < 4; corner++) begin
         cx = corner[0] ? x1 : x0;
         cy = corner[1] ? y1 : y0;
         if (!texel_loaded[{cy, cx}])
            push_request(write_item(cx, cy, rand_chan(), rand_chan(), rand_chan()));
      end
      push_request(q);
   endtask

   // Drop valid, wait for every owed sample, then let trailing writes drain
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_atlas_res(bit [RES_BITS-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.atlas_res = value;
   endtask

   // Directed part, at the reset atlas size
   task automatic run_directed();
      // Fill the low corner with rail and mixed values
      push_request(write_item(8'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000));
      push_request(write_item(8'd1, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      push_request(write_item(8'd0, 8'd1, 16'hFFFF, 16'h0000, 16'h8000));
      push_request(write_item(8'd1, 8'd1, 16'h0001, 16'hFFFE, 16'h7FFF));
      // Chart at the origin: position falls below zero, clamp both neighbors low
      send_sample(sample_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'h00000, 17'h00000));
      // Half-way between texel centers on both axes
      send_sample(sample_item(16'h0100, 16'h0100, 16'h0000, 16'h0000, 17'h00000, 17'h00000));
      // Quarter and three-quarter fractions
      send_sample(sample_item(16'h00C0, 16'h0140, 16'h0000, 16'h0000, 17'h00000, 17'h00000));
      // Exactly on a texel center: zero fraction
      send_sample(sample_item(16'h0180, 16'h0180, 16'h0000, 16'h0000, 17'h00000, 17'h00000));
      // Chart size scaled by u and v at one half
      send_sample(sample_item(16'h0000, 16'h0000, 16'h0200, 16'h0200, 17'h08000, 17'h08000));
      // Fill the high corner and sample past the far edge
      push_request(write_item(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      push_request(write_item(8'd254, 8'd255, 16'h0000, 16'hFFFF, 16'h1234));
      push_request(write_item(8'd255, 8'd254, 16'hFFFF, 16'h0000, 16'hABCD));
      push_request(write_item(8'd254, 8'd254, 16'h8001, 16'h7FFE, 16'h0000));
      send_sample(sample_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              17'h10000, 17'h10000));
      // u and v above one with every coordinate bit set
      send_sample(sample_item(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 17'h1FFFF));
      // Last texel center: upper neighbor clamps onto the lower one
      send_sample(sample_item(16'hFF80, 16'hFF80, 16'h0000, 16'h0000, 17'h00000, 17'h00000));
      send_sample(sample_item(16'hFEC0, 16'hFF40, 16'h0000, 16'h0000, 17'h00000, 17'h00000));
      // Overwrite a texel and read it back on the next transaction
      push_request(write_item(8'd0, 8'd0, 16'h1234, 16'h5678, 16'h9ABC));
      send_sample(sample_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'h00000, 17'h00000));
      // Fresh texel in the middle of the atlas, sampled once its unwritten neighbors are loaded
      push_request(write_item(8'd200, 8'd17, rand_chan(), rand_chan(), rand_chan()));
      send_sample(sample_item(16'(200 * 256 + 128), 16'(17 * 256 + 128), 16'h0000, 16'h0000,
                              17'h00000, 17'h00000));
   endtask

   // Compare every accepted response against the oldest outstanding sample
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         sb.check_response(rsp_sample_red, rsp_sample_green, rsp_sample_blue);
   end

   // Stall the response side in random stretches, with runs of no stall at all
   initial begin : rsp_ready_driver
      int unsigned stall;
      rsp_ready <= 1'b0;
      repeat (3) @(posedge clock);
      forever begin
         if (recv_burst > 0) begin
            stall = 0;
            recv_burst--;
         end else begin
            stall = idle_cycles();
            if ($urandom_range(0, 99) < 4) recv_burst = $urandom_range(5, 15);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Watchdog: end a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bilinear_atlas_texel_sampler_tb failed");
         $finish;
      end
   end

   initial begin : main_sequence
      int phase, phase_end, per_phase, res;
      bit held;
      sb              = new();
      held            = 1'b0;
      per_phase       = RANDOM_ITEMS / NUM_PHASES;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= ats_pkg::FUNC_WRITE;
      req_texel_x     <= '0;
      req_texel_y     <= '0;
      req_texel_red   <= '0;
      req_texel_green <= '0;
      req_texel_blue  <= '0;
      req_chart_x     <= '0;
      req_chart_y     <= '0;
      req_chart_w     <= '0;
      req_chart_h     <= '0;
      req_coord_u     <= '0;
      req_coord_v     <= '0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      settle();

      // Atlas sizes per phase: explicit reset value, zero and oversize, and random middles
      phase_res = '{9'd256, 9'd1, 9'd0, 9'd2, 9'd3, 9'd511, 9'd300, 9'd255,
                    9'd0, 9'd0, 9'd0, 9'd16, 9'd256};
      for (phase = 8; phase <= 10; phase++) phase_res[phase] = RES_BITS'($urandom_range(4, 254));

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         write_atlas_res(phase_res[phase]);
         res       = sb.span();
         phase_end = items_sent + per_phase;
         while (items_sent < phase_end) begin
            // Hold off the sender once mid-phase until the block has drained
            if (phase == 3 && !held && items_sent >= phase_end - per_phase / 2) begin
               settle();
               held = 1'b1;
            end
            if ($urandom_range(0, 99) < 35) begin
               if ($urandom_range(0, 99) < 70)
                  push_request(write_item(IDX_BITS'($urandom_range(0, res - 1)),
                                          IDX_BITS'($urandom_range(0, res - 1)),
                                          rand_chan(), rand_chan(), rand_chan()));
               else
                  push_request(write_item(IDX_BITS'($urandom), IDX_BITS'($urandom),
                                          rand_chan(), rand_chan(), rand_chan()));
            end else begin
               send_sample(random_sample(res));
            end
         end
         settle();
      end

      $display("run covered %0d texel writes and %0d checked samples over %0d atlas sizes",
               sb.writes_seen, sb.samples_checked, NUM_PHASES + 1);
      $display("mismatches or stray responses: %0d, outstanding samples: %0d",
               sb.errors, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("bilinear_atlas_texel_sampler_tb passed");
      end else begin
         $display("bilinear_atlas_texel_sampler_tb failed");
      end
      $finish;
   end

endmodule
